FILE: hw/rtl/srgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgc_pkg
// Shared types and constants of the stereo ramp gain / crossfade unit.
// ----------------------------------------------------------------------------
package srgc_pkg;

  // Fixed formats
  localparam int SAMPLE_W   = 24;                      // Q4.20 samples
  localparam int GAIN_W     = 18;                      // Q2.16 gains
  localparam int GAIN_FRAC  = 16;
  localparam int FRAMES_W   = 13;
  localparam int MODE_W     = 2;
  localparam int MAX_FRAMES = 4096;
  localparam int IDX_W      = 12;                      // run position
  localparam int STEP_W     = GAIN_W + 1;              // signed ramp step
  localparam int FADE_W     = GAIN_FRAC + 1;           // mix step, up to 1.0
  localparam int FADE_ONE   = 2 ** GAIN_FRAC;
  localparam int COEF_W     = GAIN_W;                  // unsigned lane coefficient

  // Lane arithmetic
  localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
  localparam int SUM_W      = PROD_W + 1;
  localparam int RND_W      = SUM_W - GAIN_FRAC;
  localparam int ACC_W      = RND_W + 1;
  localparam int ROUND_HALF = 2 ** (GAIN_FRAC - 1);

  // Divider
  localparam int DIV_W      = GAIN_W;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Configuration port
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY     = 2'd0,
    MODE_ADD      = 2'd1,
    MODE_FADE_OUT = 2'd2,
    MODE_FADE_IN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_GAIN_START = 2'd0,
    REG_GAIN_END   = 2'd1,
    REG_FRAMES     = 2'd2,
    REG_MODE       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] src_left;
    logic signed [SAMPLE_W-1:0] src_right;
    logic signed [SAMPLE_W-1:0] dest_left;
    logic signed [SAMPLE_W-1:0] dest_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       saturated;
  } out_t;

  typedef struct packed {
    logic [COEF_W-1:0] src_coef;
    logic [COEF_W-1:0] dest_coef;
  } coef_t;

  typedef struct packed {
    logic start;
    logic take;
    logic add_dest;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } lane_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/srgc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srgc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [srgc_pkg::DIV_W-1:0]    dividend_i,
  input  logic [srgc_pkg::FRAMES_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [srgc_pkg::DIV_W-1:0]    quotient_o
);
  import srgc_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [FRAMES_W-1:0]  rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [FRAMES_W:0]    trial;
  logic                 fits;
  logic [FRAMES_W-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    fits  = (trial >= {1'b0, divisor_i});
    rem_d = fits ? FRAMES_W'(trial - {1'b0, divisor_i}) : trial[FRAMES_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: hw/rtl/srgc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgc_lane
// One channel: two products, rounded sum, optional destination add, clamp.
// ----------------------------------------------------------------------------
module srgc_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srgc_pkg::lane_ctl_t                  ctl_i,
  input  logic signed [srgc_pkg::SAMPLE_W-1:0] src_i,
  input  logic signed [srgc_pkg::SAMPLE_W-1:0] dest_i,
  input  srgc_pkg::coef_t                      coef_i,
  output logic                                 valid_o,
  output srgc_pkg::lane_res_t                  res_o
);
  import srgc_pkg::*;

  logic signed [COEF_W:0]     src_coef;
  logic signed [COEF_W:0]     dest_coef;
  logic signed [PROD_W-1:0]   p_src;
  logic signed [PROD_W-1:0]   p_dst;
  logic signed [SUM_W-1:0]    sum;
  logic signed [RND_W-1:0]    rnd_d;
  logic signed [ACC_W-1:0]    dest_term;
  logic signed [ACC_W-1:0]    acc;
  logic                       ovf;
  logic signed [SAMPLE_W-1:0] clamped;

  logic                       v1_q, v2_q, valid_q;
  logic signed [PROD_W-1:0]   p_src_q, p_dst_q;
  logic signed [SAMPLE_W-1:0] dest1_q, dest2_q;
  logic                       add1_q, add2_q;
  logic signed [RND_W-1:0]    rnd_q;
  lane_res_t                  res_q;

  always_comb begin
    src_coef  = $signed({1'b0, coef_i.src_coef});
    dest_coef = $signed({1'b0, coef_i.dest_coef});
    p_src     = src_i * src_coef;
    p_dst     = dest_i * dest_coef;
    // round half up, then drop the fraction
    sum       = SUM_W'(p_src_q) + SUM_W'(p_dst_q) + SUM_W'(ROUND_HALF);
    rnd_d     = RND_W'(sum >>> GAIN_FRAC);
    dest_term = add2_q ? ACC_W'(dest2_q) : ACC_W'(0);
    acc       = ACC_W'(rnd_q) + dest_term;
    ovf       = !((&acc[ACC_W-1:SAMPLE_W-1]) || !(|acc[ACC_W-1:SAMPLE_W-1]));
    if (!ovf) begin
      clamped = acc[SAMPLE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      clamped = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.start;
      v2_q <= v1_q;
      if (v2_q) begin
        valid_q <= 1'b1;
      end else if (ctl_i.take) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      p_src_q <= p_src;
      p_dst_q <= p_dst;
      dest1_q <= dest_i;
      add1_q  <= ctl_i.add_dest;
    end
    if (v1_q) begin
      rnd_q   <= rnd_d;
      dest2_q <= dest1_q;
      add2_q  <= add1_q;
    end
    if (v2_q) begin
      res_q.sample <= clamped;
      res_q.sat    <= ovf;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/srgc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgc_merge
// Joins the two lane results into one output request and holds it.
// ----------------------------------------------------------------------------
module srgc_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srgc_pkg::lane_res_t left_i,
  input  srgc_pkg::lane_res_t right_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srgc_pkg::out_t      out_data_o
);
  import srgc_pkg::*;

  logic out_valid_q;
  out_t out_q;
  logic load;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_left  <= left_i.sample;
      out_q.out_right <= right_i.sample;
      out_q.saturated <= left_i.sat | right_i.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/stereo_ramp_gain_crossfade_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_ramp_gain_crossfade_unit
// Stereo gain ramp and linear crossfade over runs of frames.
// ----------------------------------------------------------------------------
// One frame is handled at a time. A frame inside a run passes from
// acceptance through the coefficient register, three lane pipeline stages
// and the handoff to the output stage. The first frame of a run (frame
// index zero, which any register write forces) first runs the shared
// bit-serial divider twice, for the ramp step and the mix step, latching
// each step when its division is done. The input is ready again in the cycle
// after the current frame moves into the output register; a held output
// register stalls the input.
module stereo_ramp_gain_crossfade_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srgc_pkg::PADDR_W-1:0]    paddr,
  input  logic [srgc_pkg::PDATA_W-1:0]    pwdata,
  output logic [srgc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // frames in
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  srgc_pkg::in_t                   in_data_i,
  // results out
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output srgc_pkg::out_t                  out_data_o
);
  import srgc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RAMP,
    ST_DIV_FADE,
    ST_COEF,
    ST_RUN
  } state_e;

  // Configuration registers
  logic [GAIN_W-1:0]   gain_start_q;
  logic [GAIN_W-1:0]   gain_end_q;
  logic [FRAMES_W-1:0] frames_q;
  mode_e               mode_q;
  logic                cfg_wr;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_start_q <= GAIN_W'(65536);
      gain_end_q   <= GAIN_W'(65536);
      frames_q     <= FRAMES_W'(256);
      mode_q       <= MODE_COPY;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_START: gain_start_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_END:   gain_end_q   <= pwdata[GAIN_W-1:0];
        REG_FRAMES:     frames_q     <= pwdata[FRAMES_W-1:0];
        REG_MODE:       mode_q       <= mode_e'(pwdata[MODE_W-1:0]);
        default:        mode_q       <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_START: prdata = PDATA_W'(gain_start_q);
      REG_GAIN_END:   prdata = PDATA_W'(gain_end_q);
      REG_FRAMES:     prdata = PDATA_W'(frames_q);
      REG_MODE:       prdata = PDATA_W'(mode_q);
      default:        prdata = '0;
    endcase
  end

  // Run length, limited to 1..MAX_FRAMES
  logic [FRAMES_W-1:0] nf;
  logic [FRAMES_W-1:0] idx_inc;
  logic [IDX_W-1:0]    idx_wrap;

  always_comb begin
    if (frames_q == '0) begin
      nf = FRAMES_W'(1);
    end else if (frames_q > FRAMES_W'(MAX_FRAMES)) begin
      nf = FRAMES_W'(MAX_FRAMES);
    end else begin
      nf = frames_q;
    end
  end

  // Divider operands
  logic signed [STEP_W-1:0] diff;
  logic                     diff_neg;
  logic [DIV_W-1:0]         diff_mag;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIV_W-1:0]         div_quo;
  logic                     div_done;
  logic                     div_start_q;

  // Sequencer state
  state_e                   state_q;
  logic [IDX_W-1:0]         frame_idx_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [STEP_W-1:0] ramp_step_q;
  logic [FADE_W-1:0]        fade_step_q;
  logic                     lane_start_q;
  coef_t                    coef_q;
  in_t                      in_q;

  assign idx_inc  = {1'b0, frame_idx_q} + FRAMES_W'(1);
  assign idx_wrap = (idx_inc >= nf) ? '0 : idx_inc[IDX_W-1:0];

  always_comb begin
    diff         = $signed({1'b0, gain_end_q}) - $signed({1'b0, gain_start_q});
    diff_neg     = diff[STEP_W-1];
    diff_mag     = diff_neg ? DIV_W'(-diff) : DIV_W'(diff);
    div_dividend = (state_q == ST_DIV_FADE) ? DIV_W'(FADE_ONE) : diff_mag;
  end

  srgc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend),
    .divisor_i  (nf),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Per-frame gain and mix factor
  logic [IDX_W:0]                     idx_plus;
  logic signed [STEP_W+IDX_W+1:0]     gain_prod;
  logic signed [STEP_W+IDX_W+1:0]     gain_full;
  logic [GAIN_W-1:0]                  gain;
  logic [FADE_W+IDX_W-1:0]            mix_prod;
  logic [FADE_W-1:0]                  mix;
  logic [FADE_W-1:0]                  mix_inv;
  coef_t                              coef_d;
  logic signed [STEP_W-1:0]           step_d;

  always_comb begin
    idx_plus  = {1'b0, idx_q} + (IDX_W+1)'(1);
    gain_prod = ramp_step_q * $signed({1'b0, idx_plus});
    gain_full = gain_prod + $signed({1'b0, (STEP_W+IDX_W+1)'(gain_start_q)});
    gain      = gain_full[GAIN_W-1:0];
    mix_prod  = fade_step_q * idx_q;
    mix       = mix_prod[FADE_W-1:0];
    mix_inv   = FADE_W'(FADE_ONE) - mix;
    unique case (mode_q)
      MODE_FADE_OUT: begin
        coef_d.src_coef  = COEF_W'(mix);
        coef_d.dest_coef = COEF_W'(mix_inv);
      end
      MODE_FADE_IN: begin
        coef_d.src_coef  = COEF_W'(mix_inv);
        coef_d.dest_coef = COEF_W'(mix);
      end
      default: begin
        coef_d.src_coef  = gain;
        coef_d.dest_coef = '0;
      end
    endcase
    step_d = diff_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  end

  // Lanes and merge
  lane_ctl_t  lane_ctl;
  logic [1:0] lane_valid;
  lane_res_t  res_left, res_right;
  logic       merge_ready;
  logic       take;

  assign take              = (&lane_valid) && merge_ready;
  assign lane_ctl.start    = lane_start_q;
  assign lane_ctl.take     = take;
  assign lane_ctl.add_dest = (mode_q == MODE_ADD);

  srgc_lane u_lane_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lane_ctl),
    .src_i   (in_q.src_left),
    .dest_i  (in_q.dest_left),
    .coef_i  (coef_q),
    .valid_o (lane_valid[0]),
    .res_o   (res_left)
  );

  srgc_lane u_lane_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lane_ctl),
    .src_i   (in_q.src_right),
    .dest_i  (in_q.dest_right),
    .coef_i  (coef_q),
    .valid_o (lane_valid[1]),
    .res_o   (res_right)
  );

  srgc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (&lane_valid),
    .in_ready_o  (merge_ready),
    .left_i      (res_left),
    .right_i     (res_right),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Sequencer
  logic in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      div_start_q  <= 1'b0;
      lane_start_q <= 1'b0;
      frame_idx_q  <= '0;
      idx_q        <= '0;
      ramp_step_q  <= '0;
      fade_step_q  <= '0;
      coef_q       <= '0;
    end else begin
      div_start_q  <= 1'b0;
      lane_start_q <= 1'b0;
      if (cfg_wr) begin
        frame_idx_q <= '0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q <= frame_idx_q;
            if (!cfg_wr) begin
              frame_idx_q <= idx_wrap;
            end
            if (frame_idx_q == '0) begin
              state_q     <= ST_DIV_RAMP;
              div_start_q <= 1'b1;
            end else begin
              state_q <= ST_COEF;
            end
          end
        end
        ST_DIV_RAMP: begin
          if (div_done) begin
            ramp_step_q <= step_d;
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_FADE;
          end
        end
        ST_DIV_FADE: begin
          if (div_done) begin
            fade_step_q <= div_quo[FADE_W-1:0];
            state_q     <= ST_COEF;
          end
        end
        ST_COEF: begin
          coef_q       <= coef_d;
          lane_start_q <= 1'b1;
          state_q      <= ST_RUN;
        end
        ST_RUN: begin
          // hold until both lane results move into the output stage
          if (take) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire
